// File: hdl/hat_pkg.sv
package hat_pkg;

	typedef enum logic [1:0] {
		OP_REGISTER    = 2'd0,
		OP_DEREGISTER  = 2'd1,
		OP_LOOKUP_PORT = 2'd2,
		OP_LOOKUP_HOST = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID_PORT = 3'd1,
		ST_ALREADY_SET  = 3'd2,
		ST_NOT_SET      = 3'd3,
		ST_NOT_FOUND    = 3'd4
	} status_t;

	// operation token walking down the cell chain
	typedef struct packed {
		logic        valid;
		op_t         op;
		logic        port_ok;
		logic [7:0]  port;
		status_t     status;
		logic [3:0]  found_port;
	} ctl_t;

	localparam int       FieldAddrBits  = 48;
	localparam logic [4:0] PortsReset   = 5'd16;
	localparam logic     RegPortsInUse  = 1'b0;

endpackage

// File: hdl/hat_cell.sv
module hat_cell #(
	parameter int AW  = 48,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  hat_pkg::ctl_t  ctl_in,
	input  logic [AW-1:0]  key_in,
	input  logic [AW-1:0]  fa_in,
	output hat_pkg::ctl_t  ctl_s1,
	output logic [AW-1:0]  key_s1,
	output logic [AW-1:0]  fa_s1
);
	import hat_pkg::*;

	localparam logic [7:0] CellId = 8'(IDX);

	logic          valid_q;
	logic [AW-1:0] addr_q;
	logic          hit;
	logic          match;
	logic          set_valid;
	logic          clr_valid;
	ctl_t          ctl_nx;
	logic [AW-1:0] fa_nx;

	assign hit   = ctl_in.valid && ctl_in.port_ok && (ctl_in.port == CellId);
	assign match = valid_q && (addr_q == key_in);

	always_comb begin
		ctl_nx    = ctl_in;
		fa_nx     = fa_in;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		case (ctl_in.op)
			OP_REGISTER: begin
				if (hit) begin
					if (valid_q) begin
						ctl_nx.status = ST_ALREADY_SET;
					end else begin
						set_valid = 1'b1;
					end
				end
			end
			OP_DEREGISTER: begin
				if (hit && valid_q) begin
					clr_valid     = 1'b1;
					ctl_nx.status = ST_OK;
				end
			end
			OP_LOOKUP_PORT: begin
				// first hit wins, lower cells see the token earlier
				if (ctl_in.valid && ctl_in.status == ST_NOT_FOUND && match) begin
					ctl_nx.status     = ST_OK;
					ctl_nx.found_port = CellId[3:0];
				end
			end
			OP_LOOKUP_HOST: begin
				if (hit && valid_q) begin
					ctl_nx.status = ST_OK;
					fa_nx         = addr_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_s1  <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_nx;
			if (set_valid) begin
				valid_q <= 1'b1;
			end else if (clr_valid) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s1 <= key_in;
			fa_s1  <= fa_nx;
			if (set_valid) begin
				addr_q <= key_in;
			end
		end
	end

endmodule

// File: hdl/switch_host_address_table.sv
// One table cell per chain stage; an accepted input beat is registered in the
// entry stage, then in each cell, so the chain depth (PORTS cells) sets the
// latency, not the rate. Throughput: one beat per cycle when not stalled.
// A stalled output freezes the chain; the entry stage still takes one beat.
// Reset: entry valid marks cleared, ports_in_use = 16, chain emptied.
// Entry addresses are not reset and are read only once written.
module switch_host_address_table #(
	parameter int PORTS     = 16,
	parameter int ADDR_BITS = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hat_pkg::op_t        opcode,
	input  logic [7:0]          port_index,
	input  logic [47:0]         host_address,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [3:0]          found_port,
	output logic [47:0]         found_address,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import hat_pkg::*;

	localparam int AW = (ADDR_BITS < FieldAddrBits) ? ADDR_BITS : FieldAddrBits;

	logic [4:0]    ports_q;
	logic [8:0]    limit;
	logic          port_ok;
	status_t       status_d;
	logic          adv;
	logic          ld0;
	ctl_t          ctl_s0;
	logic [AW-1:0] key_s0;

	ctl_t          ctl_c [PORTS+1];
	logic [AW-1:0] key_c [PORTS+1];
	logic [AW-1:0] fa_c  [PORTS+1];

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegPortsInUse) ? 32'(ports_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_q <= PortsReset;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegPortsInUse) begin
			ports_q <= pwdata[4:0];
		end
	end

	// entry stage
	assign limit   = (9'(ports_q) < 9'(PORTS)) ? 9'(ports_q) : 9'(PORTS);
	assign port_ok = 9'(port_index) < limit;

	always_comb begin
		case (opcode)
			OP_REGISTER:    status_d = port_ok ? ST_OK : ST_INVALID_PORT;
			OP_DEREGISTER:  status_d = port_ok ? ST_NOT_SET : ST_INVALID_PORT;
			OP_LOOKUP_PORT: status_d = ST_NOT_FOUND;
			OP_LOOKUP_HOST: status_d = port_ok ? ST_NOT_FOUND : ST_INVALID_PORT;
			default:        status_d = ST_NOT_FOUND;
		endcase
	end

	assign adv      = !out_valid || out_ready;
	assign ld0      = !ctl_s0.valid || adv;
	assign in_ready = ld0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (ld0) begin
			ctl_s0.valid <= in_valid;
			if (in_valid) begin
				ctl_s0.op         <= opcode;
				ctl_s0.port_ok    <= port_ok;
				ctl_s0.port       <= port_index;
				ctl_s0.status     <= status_d;
				ctl_s0.found_port <= 4'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld0 && in_valid) begin
			key_s0 <= host_address[AW-1:0];
		end
	end

	// cell chain
	assign ctl_c[0] = ctl_s0;
	assign key_c[0] = key_s0;
	assign fa_c[0]  = '0;

	for (genvar g = 0; g < PORTS; g++) begin : g_cell
		hat_cell #(
			.AW  (AW),
			.IDX (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_in (ctl_c[g]),
			.key_in (key_c[g]),
			.fa_in  (fa_c[g]),
			.ctl_s1 (ctl_c[g+1]),
			.key_s1 (key_c[g+1]),
			.fa_s1  (fa_c[g+1])
		);
	end

	assign out_valid     = ctl_c[PORTS].valid;
	assign status        = ctl_c[PORTS].status;
	assign found_port    = ctl_c[PORTS].found_port;
	assign found_address = 48'(fa_c[PORTS]);

	a_port_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found_port != 4'd0) |-> status == ST_OK)
		else $error("found_port set on failed beat");

	a_addr_only_on_host_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found_address != 48'd0) |->
		(status == ST_OK && ctl_c[PORTS].op == OP_LOOKUP_HOST))
		else $error("found_address set outside successful host lookup");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("result beat lost under stall");

	a_entry_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl_s0.valid |-> in_ready)
		else $error("empty entry stage refused a beat");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_INVALID_PORT ||
		status == ST_ALREADY_SET || status == ST_NOT_SET || status == ST_NOT_FOUND))
		else $error("illegal status code");

endmodule

// File: tb/sv/tb.sv
module tb;
	import hat_pkg::*;

	localparam int PORTS = 16;
	localparam int LATENCY = PORTS + 1;
	localparam int HOLD_CYCLES = 150;
	localparam logic [2:0] PORTS_REG_ADDR = {RegPortsInUse, 2'b00};

	typedef struct packed {
		status_t     st;
		logic [3:0]  port;
		logic [47:0] addr;
	} answer_t;

	typedef struct packed {
		logic        is_cfg;
		logic        typed;
		op_t         op;
		logic [7:0]  port;
		logic [47:0] addr;
		answer_t     want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	op_t         opcode;
	logic [7:0]  port_index;
	logic [47:0] host_address;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [3:0]  found_port;
	logic [47:0] found_address;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	switch_host_address_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.port_index(port_index),
		.host_address(host_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_port(found_port),
		.found_address(found_address),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// shadow of the host table
	logic [4:0]  ports_limit;
	logic        slot_valid [PORTS];
	logic [47:0] slot_addr [PORTS];

	answer_t     answers [$];
	logic        drv_typed;
	answer_t     drv_want;
	int          errors;
	int          gap_pct;
	int          stall_pct;
	logic        hold_req;
	logic [47:0] addr_pool [8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic port_in_range(logic [7:0] p);
		int lim;
		lim = (ports_limit > PORTS) ? PORTS : int'(ports_limit);
		return int'(p) < lim;
	endfunction

	function automatic answer_t apply_table_op(op_t op, logic [7:0] p, logic [47:0] a);
		answer_t r;
		int i;
		r.st = ST_OK;
		r.port = '0;
		r.addr = '0;
		case (op)
			OP_REGISTER: begin
				if (!port_in_range(p))
					r.st = ST_INVALID_PORT;
				else if (slot_valid[p[3:0]])
					r.st = ST_ALREADY_SET;
				else begin
					slot_addr[p[3:0]] = a;
					slot_valid[p[3:0]] = 1'b1;
				end
			end
			OP_DEREGISTER: begin
				if (!port_in_range(p))
					r.st = ST_INVALID_PORT;
				else if (!slot_valid[p[3:0]])
					r.st = ST_NOT_SET;
				else
					slot_valid[p[3:0]] = 1'b0;
			end
			OP_LOOKUP_PORT: begin
				r.st = ST_NOT_FOUND;
				// scan downward so the lowest matching port wins
				for (i = PORTS - 1; i >= 0; i--) begin
					if (slot_valid[i] && slot_addr[i] == a) begin
						r.st = ST_OK;
						r.port = 4'(i);
					end
				end
			end
			default: begin
				if (!port_in_range(p))
					r.st = ST_INVALID_PORT;
				else if (!slot_valid[p[3:0]])
					r.st = ST_NOT_FOUND;
				else
					r.addr = slot_addr[p[3:0]];
			end
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [47:0] want, logic [47:0] got);
		errors++;
		if (errors <= 50)
			$display("mismatch in %s: want %h got %h", what, want, got);
	endtask

	always @(posedge clk) begin : watch
		answer_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == PORTS_REG_ADDR)
				ports_limit = pwdata[4:0];
			if (out_valid && out_ready) begin
				if (answers.size() == 0)
					report("unexpected beat", '0, {45'd0, status});
				else begin
					want = answers.pop_front();
					if (status !== want.st)
						report("status", {45'd0, want.st}, {45'd0, status});
					if (found_port !== want.port)
						report("found_port", {44'd0, want.port}, {44'd0, found_port});
					if (found_address !== want.addr)
						report("found_address", want.addr, found_address);
				end
			end
			if (in_valid && in_ready) begin
				want = apply_table_op(opcode, port_index, host_address);
				if (drv_typed)
					want = drv_want;
				answers.push_back(want);
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end else
				out_ready = 1'b1;
		end
	end

	task automatic offer(row_t r);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		opcode = r.op;
		port_index = r.port;
		host_address = r.addr;
		drv_typed = r.typed;
		drv_want = r.want;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (answers.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic write_ports(logic [4:0] v);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PORTS_REG_ADDR;
		pwdata = {27'($urandom()), v};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[4:0] !== v)
			report("ports_in_use readback", {43'd0, v}, {43'd0, prdata[4:0]});
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic row_t chk(op_t op, logic [7:0] p, logic [47:0] a,
		status_t st, logic [3:0] fp, logic [47:0] fa);
		row_t r;
		r.is_cfg = 1'b0;
		r.typed = 1'b1;
		r.op = op;
		r.port = p;
		r.addr = a;
		r.want.st = st;
		r.want.port = fp;
		r.want.addr = fa;
		return r;
	endfunction

	function automatic row_t pred(op_t op, logic [7:0] p, logic [47:0] a);
		row_t r;
		r = chk(op, p, a, ST_OK, '0, '0);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic row_t cfg(logic [4:0] v);
		row_t r;
		r = pred(OP_REGISTER, {3'd0, v}, '0);
		r.is_cfg = 1'b1;
		return r;
	endfunction

	initial begin
		row_t        plan [$];
		row_t        r;
		logic [4:0]  phase_lim [8];
		int          ph;
		int          k;
		int          eff;
		int          roll;
		localparam logic [47:0] ONES = 48'hFFFF_FFFF_FFFF;

		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_REGISTER;
		port_index = '0;
		host_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		drv_typed = 1'b0;
		drv_want = '0;
		errors = 0;
		gap_pct = 20;
		stall_pct = 20;
		hold_req = 1'b0;
		ports_limit = PortsReset;
		for (k = 0; k < PORTS; k++) begin
			slot_valid[k] = 1'b0;
			slot_addr[k] = '0;
		end

		plan.push_back(chk(OP_LOOKUP_HOST, 8'd0, '0, ST_NOT_FOUND, '0, '0));
		plan.push_back(chk(OP_LOOKUP_PORT, 8'd0, '0, ST_NOT_FOUND, '0, '0));
		plan.push_back(chk(OP_DEREGISTER, 8'd0, '0, ST_NOT_SET, '0, '0));
		plan.push_back(chk(OP_REGISTER, 8'd16, ONES, ST_INVALID_PORT, '0, '0));
		plan.push_back(chk(OP_REGISTER, 8'd255, ONES, ST_INVALID_PORT, '0, '0));
		plan.push_back(chk(OP_REGISTER, 8'd0, ONES, ST_OK, '0, '0));
		plan.push_back(chk(OP_REGISTER, 8'd0, '0, ST_ALREADY_SET, '0, '0));
		plan.push_back(chk(OP_LOOKUP_HOST, 8'd0, '0, ST_OK, '0, ONES));
		plan.push_back(chk(OP_LOOKUP_PORT, 8'd255, ONES, ST_OK, '0, '0));
		plan.push_back(chk(OP_REGISTER, 8'd15, '0, ST_OK, '0, '0));
		plan.push_back(chk(OP_REGISTER, 8'd7, '0, ST_OK, '0, '0));
		plan.push_back(pred(OP_LOOKUP_PORT, 8'd0, '0));
		plan.push_back(chk(OP_LOOKUP_HOST, 8'd15, ONES, ST_OK, '0, '0));
		plan.push_back(chk(OP_LOOKUP_HOST, 8'd16, '0, ST_INVALID_PORT, '0, '0));
		plan.push_back(chk(OP_DEREGISTER, 8'd255, '0, ST_INVALID_PORT, '0, '0));
		plan.push_back(chk(OP_DEREGISTER, 8'd7, '0, ST_OK, '0, '0));
		plan.push_back(pred(OP_LOOKUP_PORT, 8'd0, '0));
		plan.push_back(pred(OP_REGISTER, 8'd3, 48'h5555_5555_5555));
		plan.push_back(pred(OP_REGISTER, 8'd12, 48'hAAAA_AAAA_AAAA));
		plan.push_back(pred(OP_LOOKUP_PORT, 8'd0, 48'hAAAA_AAAA_AAAA));
		// narrow the port range below entries already set
		plan.push_back(cfg(5'd4));
		plan.push_back(pred(OP_LOOKUP_PORT, 8'd0, '0));
		plan.push_back(chk(OP_LOOKUP_HOST, 8'd12, '0, ST_INVALID_PORT, '0, '0));
		plan.push_back(chk(OP_DEREGISTER, 8'd4, '0, ST_INVALID_PORT, '0, '0));
		plan.push_back(pred(OP_LOOKUP_HOST, 8'd3, '0));
		plan.push_back(cfg(5'd0));
		plan.push_back(chk(OP_REGISTER, 8'd0, 48'd1, ST_INVALID_PORT, '0, '0));
		plan.push_back(pred(OP_LOOKUP_PORT, 8'd0, ONES));
		plan.push_back(cfg(5'd31));
		plan.push_back(chk(OP_REGISTER, 8'd15, 48'd1, ST_ALREADY_SET, '0, '0));
		plan.push_back(pred(OP_DEREGISTER, 8'd15, '0));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_ports(plan[i].port[4:0]);
			end else
				offer(plan[i]);
		end

		phase_lim = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16};
		for (ph = 0; ph < 8; ph++) begin
			settle();
			write_ports(phase_lim[ph]);
			if (ph == 7) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 15 * $urandom_range(0, 2);
				stall_pct = 15 * $urandom_range(0, 2);
			end
			if (ph == 1)
				hold_req = 1'b1;
			for (k = 0; k < 8; k++)
				addr_pool[k] = 48'({$urandom(), $urandom()});
			addr_pool[0] = ph[0] ? ONES : '0;
			eff = (phase_lim[ph] > PORTS) ? PORTS : int'(phase_lim[ph]);
			repeat (200) begin
				r = pred(op_t'($urandom_range(0, 3)), '0, '0);
				roll = $urandom_range(0, 9);
				if (roll < 6)
					r.port = 8'((eff > 0) ? $urandom_range(0, eff - 1) : 0);
				else if (roll < 8)
					r.port = 8'($urandom_range(0, PORTS + 1));
				else
					r.port = 8'($urandom());
				if ($urandom_range(0, 9) < 8)
					r.addr = addr_pool[$urandom_range(0, 7)];
				else
					r.addr = 48'({$urandom(), $urandom()});
				offer(r);
			end
		end

		settle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: sim.f
hdl/hat_pkg.sv
hdl/hat_cell.sv
hdl/switch_host_address_table.sv
tb/sv/tb.sv
